FILE: hdl/cnmt_pkg.sv
// Shared types and constants for the CANopen NMT frame dispatch block.
// No dependencies; imported by cnmt_decode and canopen_nmt_frame_dispatch.

package cnmt_pkg;

  // NMT states as reported on the result channel
  localparam logic [6:0] STATE_STOPPED     = 7'd4;
  localparam logic [6:0] STATE_OPERATIONAL = 7'd5;
  localparam logic [6:0] STATE_PREOP       = 7'd127;

  // NMT command specifiers (byte 0 of an NMT frame)
  localparam logic [7:0] CMD_START      = 8'h01;
  localparam logic [7:0] CMD_STOP       = 8'h02;
  localparam logic [7:0] CMD_PREOP      = 8'h80;
  localparam logic [7:0] CMD_RESET_NODE = 8'h81;
  localparam logic [7:0] CMD_RESET_COMM = 8'h82;

  // Identifier bases
  localparam logic [10:0] ID_NMT            = 11'h000;
  localparam logic [10:0] ID_SETPOINT_BASE  = 11'h200;
  localparam logic [10:0] ID_LIMITS_BASE    = 11'h300;
  localparam logic [10:0] ID_HEARTBEAT_BASE = 11'h700;

  localparam logic [3:0] NMT_MIN_LENGTH = 4'd2;
  localparam logic [3:0] MAX_LENGTH     = 4'd8;
  localparam logic [7:0] TARGET_ALL     = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] REG_NODE_ID      = 2'd0;
  localparam logic [1:0] REG_SETPOINT_MIN = 2'd1;
  localparam logic [1:0] REG_LIMITS_MIN   = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_SETPOINT = 2'd1,
    ACT_LIMITS   = 2'd2,
    ACT_BOOTUP   = 2'd3
  } action_t;

  // One received frame
  typedef struct packed {
    logic [62:0] rx_time;
    logic [63:0] frame_data;
    logic [3:0]  frame_length;
    logic        remote;
    logic        extended;
    logic [10:0] frame_id;
  } frame_t;

  // Configuration seen by the decoder
  typedef struct packed {
    logic [6:0] node_id;
    logic [3:0] setpoint_min_length;
    logic [3:0] limits_min_length;
  } cfg_t;

  // Decision for one frame
  typedef struct packed {
    action_t     action;
    logic [63:0] payload;
    logic [62:0] payload_time;
    logic        stop_valid;
    logic        stop_value;
    logic [10:0] boot_frame_id;
    logic [6:0]  node_state;
  } decision_t;

endpackage

FILE: hdl/canopen_nmt_frame_dispatch.sv
// Top level of the CANopen NMT slave frame dispatch: input register,
// decision via cnmt_decode, result register. Depends on cnmt_pkg, cnmt_decode.
//
//  channel | direction | handshake          | contents
//  in_     | slave     | tvalid/tready      | one received CAN frame
//  out_    | master    | tvalid/tready      | one decision per frame
//  cfg_    | slave     | valid/ready        | register index and write data
//
// One frame per cycle sustained while the output is not stalled; a frame passes
// from input acceptance to result valid through the input register, then the result register.
// The NMT state and frame counter update when a frame moves into the
// result register, so back-to-back frames see each other's state.
// A stalled output holds the result register; the input register still
// takes one more request, after which in_tready drops.
// rst_n is synchronous, active low; configuration takes its reset values.

module canopen_nmt_frame_dispatch
  import cnmt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: frame_id[10:0], frame_length[14:11], frame_data[78:15],
  //           rx_time[141:79], zero fill [143:142]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,
  // in_tuser: extended[0], remote[1]
  input  logic [1:0]   in_tuser,
  // out_tdata: payload[63:0], payload_time[126:64], stop_request_valid[127],
  //            stop_request_value[128], boot_frame_id[139:129],
  //            node_state[146:140], frames_seen[178:147], zero fill [183:179]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [183:0] out_tdata,
  // out_tuser: action[1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  cfg_t       cfg_r;
  frame_t     frame_r;
  logic       frame_valid_r;
  logic [6:0] nmt_state_r;
  logic [31:0] counter_r;
  logic [31:0] counter_nxt;
  decision_t  dec;
  decision_t  result_r;
  logic [31:0] frames_seen_r;
  logic       out_valid_r;
  logic       advance;
  logic       in_accept;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !frame_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign counter_nxt = counter_r + 32'd1;

  cnmt_decode u_decode (
    .frame     (frame_r),
    .cfg       (cfg_r),
    .nmt_state (nmt_state_r),
    .dec       (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id             <= 7'd1;
      cfg_r.setpoint_min_length <= 4'd8;
      cfg_r.limits_min_length   <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_ID:      cfg_r.node_id             <= cfg_data;
        REG_SETPOINT_MIN: cfg_r.setpoint_min_length <= cfg_data[3:0];
        REG_LIMITS_MIN:   cfg_r.limits_min_length   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
    end else if (in_tready) begin
      frame_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_r.frame_id     <= in_tdata[10:0];
      frame_r.frame_length <= in_tdata[14:11];
      frame_r.frame_data   <= in_tdata[78:15];
      frame_r.rx_time      <= in_tdata[141:79];
      frame_r.extended     <= in_tuser[0];
      frame_r.remote       <= in_tuser[1];
    end
  end

  // node state, counter and result register advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmt_state_r <= STATE_PREOP;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= frame_valid_r;
      if (frame_valid_r) begin
        nmt_state_r <= dec.node_state;
        counter_r   <= counter_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_valid_r) begin
      result_r      <= dec;
      frames_seen_r <= counter_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = result_r.action;
  assign out_tdata  = {5'b00000,
                       frames_seen_r,
                       result_r.node_state,
                       result_r.boot_frame_id,
                       result_r.stop_value,
                       result_r.stop_valid,
                       result_r.payload_time,
                       result_r.payload};

endmodule

FILE: hdl/cnmt_decode.sv
// Frame decision logic: classifies one frame and yields the next NMT state.
// Depends on cnmt_pkg.

module cnmt_decode
  import cnmt_pkg::*;
(
  input  frame_t     frame,
  input  cfg_t       cfg,
  input  logic [6:0] nmt_state,
  output decision_t  dec
);

  logic [3:0]  len;
  logic [7:0]  cmd;
  logic [7:0]  target;
  logic [10:0] node_ext;
  logic [10:0] setpoint_id;
  logic [10:0] limits_id;
  logic        nmt_for_us;

  assign len         = (frame.frame_length > MAX_LENGTH) ? MAX_LENGTH : frame.frame_length;
  assign cmd         = frame.frame_data[7:0];
  assign target      = frame.frame_data[15:8];
  assign node_ext    = {4'b0000, cfg.node_id};
  assign setpoint_id = ID_SETPOINT_BASE + node_ext;
  assign limits_id   = ID_LIMITS_BASE + node_ext;
  assign nmt_for_us  = (len >= NMT_MIN_LENGTH) &&
                       ((target == TARGET_ALL) || (target == {1'b0, cfg.node_id}));

  always_comb begin
    dec.action        = ACT_NONE;
    dec.payload       = '0;
    dec.payload_time  = '0;
    dec.stop_valid    = 1'b0;
    dec.stop_value    = 1'b0;
    dec.boot_frame_id = '0;
    dec.node_state    = nmt_state;

    // drop extended and remote frames; they are only counted
    if (!frame.extended && !frame.remote) begin
      if (frame.frame_id == ID_NMT) begin
        if (nmt_for_us) begin
          unique case (cmd) inside
            CMD_START: begin
              dec.node_state = STATE_OPERATIONAL;
            end
            CMD_STOP: begin
              dec.node_state = STATE_STOPPED;
              dec.stop_valid = 1'b1;
              dec.stop_value = 1'b1;
            end
            CMD_PREOP: begin
              dec.node_state = STATE_PREOP;
              dec.stop_valid = 1'b1;
              dec.stop_value = 1'b1;
            end
            CMD_RESET_NODE, CMD_RESET_COMM: begin
              dec.node_state    = STATE_PREOP;
              dec.stop_valid    = 1'b1;
              dec.action        = ACT_BOOTUP;
              dec.boot_frame_id = ID_HEARTBEAT_BASE + node_ext;
            end
            default: begin
            end
          endcase
        end
      end else if (frame.frame_id == setpoint_id) begin
        if ((len >= cfg.setpoint_min_length) && (nmt_state == STATE_OPERATIONAL)) begin
          dec.action       = ACT_SETPOINT;
          dec.payload      = frame.frame_data;
          dec.payload_time = frame.rx_time;
        end
      end else if (frame.frame_id == limits_id) begin
        if (len >= cfg.limits_min_length) begin
          dec.action  = ACT_LIMITS;
          dec.payload = frame.frame_data;
        end
      end
    end
  end

endmodule
